/* src/tksd_pkg.sv */
// tksd_pkg: key codes, byte values and payload types for the terminal key decoder
// no dependencies; used by the channel interfaces and the top level
`timescale 1ns / 1ps

package tksd_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [4:0] key_code_t;

	// key codes on the result channel
	localparam key_code_t KEY_CHAR  = 5'd0;
	localparam key_code_t KEY_BS    = 5'd1;
	localparam key_code_t KEY_ENTER = 5'd2;
	localparam key_code_t KEY_UP    = 5'd3;
	localparam key_code_t KEY_DEL   = 5'd7;
	localparam key_code_t KEY_INS   = 5'd8;
	localparam key_code_t KEY_F1    = 5'd9;
	localparam key_code_t KEY_F5    = 5'd13;
	localparam key_code_t KEY_F6    = 5'd14;
	localparam key_code_t KEY_F7    = 5'd15;
	localparam key_code_t KEY_F8    = 5'd16;
	localparam key_code_t KEY_F9    = 5'd17;
	localparam key_code_t KEY_F10   = 5'd18;
	localparam key_code_t KEY_F11   = 5'd19;
	localparam key_code_t KEY_F12   = 5'd20;

	// received byte values
	localparam byte_t BYTE_BS    = 8'd8;
	localparam byte_t BYTE_LF    = 8'd10;
	localparam byte_t BYTE_ESC   = 8'd27;
	localparam byte_t BYTE_0     = 8'd48;
	localparam byte_t BYTE_1     = 8'd49;
	localparam byte_t BYTE_2     = 8'd50;
	localparam byte_t BYTE_3     = 8'd51;
	localparam byte_t BYTE_4     = 8'd52;
	localparam byte_t BYTE_5     = 8'd53;
	localparam byte_t BYTE_7     = 8'd55;
	localparam byte_t BYTE_8     = 8'd56;
	localparam byte_t BYTE_9     = 8'd57;
	localparam byte_t BYTE_A     = 8'd65;
	localparam byte_t BYTE_D     = 8'd68;
	localparam byte_t BYTE_O     = 8'd79;
	localparam byte_t BYTE_P     = 8'd80;
	localparam byte_t BYTE_S     = 8'd83;
	localparam byte_t BYTE_LBRKT = 8'd91;
	localparam byte_t BYTE_TILDE = 8'd126;

endpackage

/* src/tksd_if.sv */
// tksd_byte_if and tksd_key_if: valid/ready channels of the terminal key decoder
// depends on tksd_pkg for the payload types
`timescale 1ns / 1ps

interface tksd_byte_if import tksd_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface tksd_key_if import tksd_pkg::*; ();
	logic      valid;
	logic      ready;
	key_code_t key_code;
	byte_t     char_byte;

	modport source (output valid, output key_code, output char_byte, input ready);
	modport sink (input valid, input key_code, input char_byte, output ready);
endinterface

/* src/terminal_key_sequence_decoder.sv */
// terminal_key_sequence_decoder: turns received terminal bytes into key codes
// depends on tksd_pkg and the channel interfaces in tksd_if.sv
//
//   channel  dir  payload               transfer
//   rx       in   rx_byte[7:0]          rx.valid & rx.ready
//   key      out  key_code[4:0],        key.valid & key.ready
//                 char_byte[7:0]
//
// one byte per cycle while the key channel is not stalled; a byte sits in the input
// register, where the parser state and decode act on it, and its key (if any) is
// then loaded into the result register
// the parser state register is the only loop, one transition per byte
// reset returns the parser to idle and empties both registers
// a stalled key holds the result register; the input register still takes one byte
`timescale 1ns / 1ps

module terminal_key_sequence_decoder import tksd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	tksd_byte_if.sink   rx,
	tksd_key_if.source  key
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ESC,
		ST_CSI,
		ST_SS3,
		ST_CSI1,
		ST_CSI2,
		ST_SWALLOW
	} state_t;

	state_t    state_q;
	state_t    state_nxt;
	logic      byte_valid_s1;
	byte_t     byte_s1;
	logic      advance;
	logic      emit;
	key_code_t kc;
	byte_t     ch;
	logic      key_valid_q;
	key_code_t key_code_q;
	byte_t     char_byte_q;

	// the held byte moves on whenever the result register is free or being drained
	assign advance  = !key_valid_q || key.ready;
	assign rx.ready = !byte_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			byte_valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_comb begin
		state_nxt = state_q;
		emit      = 1'b0;
		kc        = KEY_CHAR;
		ch        = '0;
		if (state_q == ST_SWALLOW) begin
			state_nxt = ST_IDLE;
		end else if (byte_s1 == BYTE_ESC) begin
			state_nxt = ST_ESC;
		end else begin
			unique case (state_q)
				ST_ESC: begin
					if (byte_s1 == BYTE_LBRKT) begin
						state_nxt = ST_CSI;
					end else if (byte_s1 == BYTE_O) begin
						state_nxt = ST_SS3;
					end else begin
						state_nxt = ST_IDLE;
						emit      = 1'b1;
						case (byte_s1)
							BYTE_BS: kc = KEY_BS;
							BYTE_LF: kc = KEY_ENTER;
							default: ch = byte_s1;
						endcase
					end
				end
				ST_CSI: begin
					state_nxt = ST_IDLE;
					if (byte_s1 >= BYTE_A && byte_s1 <= BYTE_D) begin
						emit = 1'b1;
						kc   = KEY_UP + 5'(byte_s1 - BYTE_A);
					end else begin
						case (byte_s1)
							BYTE_1: state_nxt = ST_CSI1;
							BYTE_2: state_nxt = ST_CSI2;
							BYTE_3: begin
								state_nxt = ST_SWALLOW;
								emit      = 1'b1;
								kc        = KEY_DEL;
							end
							BYTE_TILDE: begin
								state_nxt = ST_SWALLOW;
								emit      = 1'b1;
								kc        = KEY_INS;
							end
							default: state_nxt = ST_IDLE;
						endcase
					end
				end
				ST_SS3: begin
					state_nxt = ST_IDLE;
					if (byte_s1 >= BYTE_P && byte_s1 <= BYTE_S) begin
						emit = 1'b1;
						kc   = KEY_F1 + 5'(byte_s1 - BYTE_P);
					end
				end
				ST_CSI1: begin
					state_nxt = ST_SWALLOW;
					emit      = 1'b1;
					case (byte_s1)
						BYTE_5: kc = KEY_F5;
						BYTE_7: kc = KEY_F6;
						BYTE_8: kc = KEY_F7;
						BYTE_9: kc = KEY_F8;
						default: begin
							state_nxt = ST_IDLE;
							emit      = 1'b0;
						end
					endcase
				end
				ST_CSI2: begin
					state_nxt = ST_SWALLOW;
					emit      = 1'b1;
					case (byte_s1)
						BYTE_0: kc = KEY_F9;
						BYTE_1: kc = KEY_F10;
						BYTE_3: kc = KEY_F11;
						BYTE_4: kc = KEY_F12;
						default: begin
							state_nxt = ST_IDLE;
							emit      = 1'b0;
						end
					endcase
				end
				default: begin
					// idle, and the unused code, decode a plain byte
					state_nxt = ST_IDLE;
					emit      = 1'b1;
					case (byte_s1)
						BYTE_BS: kc = KEY_BS;
						BYTE_LF: kc = KEY_ENTER;
						default: ch = byte_s1;
					endcase
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			key_valid_q <= 1'b0;
			key_code_q  <= KEY_CHAR;
			char_byte_q <= '0;
		end else if (advance) begin
			key_valid_q <= byte_valid_s1 && emit;
			if (byte_valid_s1) begin
				state_q     <= state_nxt;
				key_code_q  <= kc;
				char_byte_q <= ch;
			end
		end
	end

	assign key.valid     = key_valid_q;
	assign key.key_code  = key_code_q;
	assign key.char_byte = char_byte_q;

	// a delete or insert key always leaves the parser dropping the next byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && byte_valid_s1 && emit && (kc == KEY_DEL || kc == KEY_INS))
		|=> (state_q == ST_SWALLOW))
	else $error("delete/insert did not enter the swallow state");

	// the input side only stalls when both registers are full
	assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> (byte_valid_s1 && key_valid_q))
	else $error("input stalled with a free register");

	// char_byte carries data only for plain characters
	assert property (@(posedge clk) disable iff (!arst_n)
		key.valid |-> (key.key_code == KEY_CHAR || key.char_byte == 8'd0))
	else $error("char_byte nonzero on a non-character key");

	// no key code beyond F12 is ever produced
	assert property (@(posedge clk) disable iff (!arst_n)
		key.valid |-> (key.key_code <= KEY_F12))
	else $error("key code out of range");

endmodule
